FILE: rtl/hglc_pkg.sv
// ----------------------------------------------------------------------------
// hglc_pkg
// Shared types, constants and tables of the GET request-line checker and
// its path hash unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hglc_pkg;

	// request limits
	localparam int MAX_REQUEST_BYTES = 4096;
	localparam int BLOCK_BYTES       = 16;
	localparam int CNT_W             = $clog2(MAX_REQUEST_BYTES + 2);
	localparam int IDX_W             = $clog2(BLOCK_BYTES);
	localparam int PATH_W            = 12;
	localparam int VERSION_LEN       = 10;

	// match words
	localparam logic [31:0] METHOD_GET = 32'h2054_4547;
	localparam logic [31:0] TAIL_CRLF2 = 32'h0A0D_0A0D;
	localparam logic [7:0]  SPACE_CHAR = 8'h20;

	// final mix multipliers
	localparam logic [31:0] FMIX_C1 = 32'h85eb_ca6b;
	localparam logic [31:0] FMIX_C2 = 32'hc2b2_ae35;

	// one hash block, byte 0 in the low bits
	typedef logic [BLOCK_BYTES-1:0][7:0] blk_t;

	// result codes
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_REQ    = 3'd1,
		ST_METHOD     = 3'd2,
		ST_INVALID    = 3'd3,
		ST_TOO_LONG   = 3'd4,
		ST_VERSION    = 3'd5,
		ST_INCOMPLETE = 3'd6
	} status_t;

	// top level sequencer
	typedef enum logic [2:0] {
		T_IDLE,
		T_ABS,
		T_WAIT,
		T_FIN,
		T_RES
	} top_state_t;

	// hash unit sequencer
	typedef enum logic [3:0] {
		H_IDLE,
		H_MA,
		H_MB,
		H_MX,
		H_XOR,
		H_SUM,
		H_SPR,
		H_F1,
		H_F2,
		H_F3
	} hash_state_t;

	// control into the hash unit
	typedef struct packed {
		logic start;
		logic clear;
	} hash_ctl_t;

	// status out of the hash unit
	typedef struct packed {
		logic busy;
		logic done;
	} hash_sts_t;

	function automatic logic [31:0] rotr17(input logic [31:0] x);
		return {x[16:0], x[31:17]};
	endfunction

	function automatic logic [31:0] mul_a(input logic [1:0] j);
		logic [31:0] r;
		unique case (j)
			2'd0: r = 32'h239b_961b;
			2'd1: r = 32'hab0e_9789;
			2'd2: r = 32'h38b3_4ae5;
			2'd3: r = 32'ha1e3_8b93;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] mul_b(input logic [1:0] j);
		return mul_a(j + 2'd1);
	endfunction

	function automatic logic [31:0] add_c(input logic [1:0] j);
		logic [31:0] r;
		unique case (j)
			2'd0: r = 32'h561c_cd1b;
			2'd1: r = 32'h0bca_a747;
			2'd2: r = 32'h96cd_1c35;
			2'd3: r = 32'h32ac_3b17;
			default: r = '0;
		endcase
		return r;
	endfunction

	// "HTTP/1.1\r\n"
	function automatic logic [7:0] version_char(input logic [3:0] i);
		logic [7:0] r;
		unique case (i)
			4'd0: r = 8'h48;
			4'd1: r = 8'h54;
			4'd2: r = 8'h54;
			4'd3: r = 8'h50;
			4'd4: r = 8'h2F;
			4'd5: r = 8'h31;
			4'd6: r = 8'h2E;
			4'd7: r = 8'h31;
			4'd8: r = 8'h0D;
			4'd9: r = 8'h0A;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/hglc_hash.sv
// ----------------------------------------------------------------------------
// hglc_hash
// Path hash unit: absorbs one 16-byte block per start with a single shared
// 32x32 multiplier, and finalizes when the block holds a space.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hglc_hash (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hglc_pkg::hash_ctl_t ctl,
	input  wire hglc_pkg::blk_t    blk,
	input  wire logic [31:0]       len,
	output hglc_pkg::hash_sts_t    sts,
	output logic [63:0]            lanes01
);
	import hglc_pkg::*;

	hash_state_t st_q, st_d;
	logic [1:0]  j_q;
	logic        ph_q;
	logic        fin_q;
	logic        done_q;
	logic [31:0] t_q, s_q;
	logic [31:0] lane_q [4];
	logic [31:0] hh_q [4];
	logic [31:0] w_q [4];
	logic [31:0] len_q;

	logic [31:0] op_a, op_b, prod;
	logic [31:0] lane_j, sum_j, mix_j;
	logic        has_sp;
	logic [IDX_W-1:0] last_sp;
	blk_t        fin_blk;

	// last space in the incoming block, and the masked block
	always_comb begin
		has_sp  = 1'b0;
		last_sp = '0;
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			if (blk[i] == SPACE_CHAR) begin
				has_sp  = 1'b1;
				last_sp = IDX_W'(i);
			end
		end
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			fin_blk[i] = (has_sp && IDX_W'(i) <= last_sp) ? ~blk[i] : blk[i];
			if (has_sp && IDX_W'(i) > last_sp)
				fin_blk[i] = 8'h00;
		end
	end

	// shared multiplier, operands by step
	assign lane_j = lane_q[j_q];
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (st_q)
			H_MA: begin
				op_a = w_q[j_q];
				op_b = mul_a(j_q);
			end
			H_MB: begin
				op_a = rotr17(t_q);
				op_b = mul_b(j_q);
			end
			H_F1: begin
				op_a = lane_j ^ (lane_j >> 16);
				op_b = FMIX_C1;
			end
			H_F2: begin
				op_a = t_q ^ (t_q >> 13);
				op_b = FMIX_C2;
			end
			H_F3: begin
				op_a = t_q;
				op_b = t_q >> 16;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end
	assign prod = op_a * op_b;

	// lane mix: (h[j] + h[j+1]) * 5 + c[j]
	assign sum_j = hh_q[j_q] + hh_q[j_q + 2'd1];
	assign mix_j = sum_j + (sum_j << 2) + add_c(j_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			H_IDLE: if (ctl.start) st_d = H_MA;
			H_MA:   st_d = H_MB;
			H_MB:   st_d = (j_q == 2'd3) ? H_MX : H_MA;
			H_MX: begin
				if (j_q == 2'd3)
					st_d = fin_q ? H_XOR : H_IDLE;
			end
			H_XOR:  st_d = H_SUM;
			H_SUM:  st_d = H_SPR;
			H_SPR:  st_d = ph_q ? H_IDLE : H_F1;
			H_F1:   st_d = H_F2;
			H_F2:   st_d = H_F3;
			H_F3:   st_d = (j_q == 2'd3) ? H_SUM : H_F1;
			default: st_d = H_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q    <= '0;
			ph_q   <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < 4; i++) lane_q[i] <= '0;
		end else begin
			unique case (st_q)
				H_IDLE: begin
					if (ctl.clear) begin
						done_q <= 1'b0;
						for (int i = 0; i < 4; i++) lane_q[i] <= '0;
					end else if (ctl.start) begin
						j_q   <= '0;
						ph_q  <= 1'b0;
						fin_q <= has_sp;
						len_q <= len;
						for (int i = 0; i < 4; i++)
							w_q[i] <= {fin_blk[4*i+3], fin_blk[4*i+2],
								fin_blk[4*i+1], fin_blk[4*i]};
					end
				end
				H_MA: t_q <= prod;
				H_MB: begin
					hh_q[j_q] <= lane_j ^ prod;
					j_q       <= j_q + 2'd1;
				end
				H_MX: begin
					lane_q[j_q] <= mix_j;
					j_q         <= j_q + 2'd1;
				end
				H_XOR: begin
					for (int i = 0; i < 4; i++) lane_q[i] <= lane_q[i] ^ len_q;
				end
				H_SUM: s_q <= lane_q[0] + lane_q[1] + lane_q[2] + lane_q[3];
				H_SPR: begin
					for (int i = 1; i < 4; i++) lane_q[i] <= lane_q[i] + s_q;
					j_q  <= '0;
					ph_q <= 1'b1;
					if (ph_q) done_q <= 1'b1;
				end
				H_F1: t_q <= prod;
				H_F2: t_q <= prod;
				H_F3: begin
					lane_q[j_q] <= prod;
					j_q         <= j_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	assign sts.busy = (st_q != H_IDLE);
	assign sts.done = done_q;
	assign lanes01  = {lane_q[1], lane_q[0]};

endmodule

`default_nettype wire

FILE: rtl/http_get_line_check_and_path_hash.sv
// ----------------------------------------------------------------------------
// http_get_line_check_and_path_hash
// Checks a GET request line byte by byte and hashes the path area.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_*     | in  | tdata[7:0] request byte, tlast final byte of request
//  m_*     | out | tdata: status[2:0], path_hash[66:3], path_length[78:67]
//
//  When a byte closes a 16-byte block, s_tready stays low while the shared
//  multiplier of the hash unit absorbs it, and also while the hash is
//  finalized when the block holds the first space. After the final byte,
//  one padded block is absorbed when needed before the result is formed.
//  s_tready is low while a block absorbs or a result is being formed; a
//  result waits in the output register until taken. Reset clears the
//  control state; the block buffer is rewritten before it is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_get_line_check_and_path_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // byte_in
	input  wire logic        s_tlast,   // is_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata    // status, path_hash, path_length, pad
);
	import hglc_pkg::*;

	top_state_t        st_q, st_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       method_q;
	blk_t              buf_q;
	logic              space_q;
	logic [PATH_W-1:0] uri_q;
	logic [PATH_W-1:0] bstart_q;
	logic [3:0]        vm_q;
	logic              vok_q;
	logic [31:0]       tail_q;
	logic              last_q;
	logic              pad_q;
	logic              m_valid_q;
	logic [79:0]       m_data_q;

	hash_ctl_t         hctl;
	hash_sts_t         hsts;
	logic [63:0]       lanes01;

	logic              acc, in_rng, past_hdr, need_abs, need_pad, out_free;
	logic [IDX_W-1:0]  idx, fill;
	status_t           status;
	logic              show;

	hglc_hash u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (hctl),
		.blk     (buf_q),
		.len     ({{(32-PATH_W){1'b0}}, uri_q}),
		.sts     (hsts),
		.lanes01 (lanes01)
	);

	assign s_tready = (st_q == T_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign in_rng   = cnt_q < CNT_W'(MAX_REQUEST_BYTES);
	assign past_hdr = cnt_q >= CNT_W'(4);
	assign idx      = IDX_W'(cnt_q - CNT_W'(4));
	assign fill     = IDX_W'(cnt_q - CNT_W'(4));
	assign need_abs = in_rng && past_hdr && (idx == IDX_W'(BLOCK_BYTES - 1)) && !hsts.done;
	assign need_pad = (cnt_q <= CNT_W'(MAX_REQUEST_BYTES)) && !hsts.done &&
		(cnt_q > CNT_W'(4)) && (fill != '0) && !pad_q;
	assign out_free = !m_valid_q || m_tready;

	// result checks in priority order
	always_comb begin
		show   = 1'b0;
		status = ST_OK;
		priority if (cnt_q > CNT_W'(MAX_REQUEST_BYTES)) begin
			status = ST_TOO_LONG;
		end else if (cnt_q < CNT_W'(16)) begin
			status = ST_BAD_REQ;
		end else if (method_q != METHOD_GET) begin
			status = ST_METHOD;
		end else if (!hsts.done ||
				CNT_W'(bstart_q) >= (cnt_q - CNT_W'(16))) begin
			status = ST_INVALID;
		end else begin
			show = 1'b1;
			priority if (CNT_W'(uri_q) >= cnt_q)
				status = ST_TOO_LONG;
			else if (!(vok_q && vm_q == 4'(VERSION_LEN)))
				status = ST_VERSION;
			else if (tail_q != TAIL_CRLF2)
				status = ST_INCOMPLETE;
			else
				status = ST_OK;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state and hash control
	always_comb begin
		st_d       = st_q;
		hctl.start = 1'b0;
		hctl.clear = 1'b0;
		unique case (st_q)
			T_IDLE: begin
				if (acc) begin
					if (need_abs) st_d = T_ABS;
					else if (s_tlast) st_d = T_FIN;
				end
			end
			T_ABS: begin
				hctl.start = 1'b1;
				st_d       = T_WAIT;
			end
			T_WAIT: begin
				if (!hsts.busy) st_d = last_q ? T_FIN : T_IDLE;
			end
			T_FIN: st_d = need_pad ? T_ABS : T_RES;
			T_RES: begin
				if (out_free) begin
					hctl.clear = 1'b1;
					st_d       = T_IDLE;
				end
			end
			default: st_d = T_IDLE;
		endcase
	end

	// request state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			method_q  <= '0;
			space_q   <= 1'b0;
			uri_q     <= '0;
			bstart_q  <= '0;
			vm_q      <= '0;
			vok_q     <= 1'b0;
			tail_q    <= '0;
			last_q    <= 1'b0;
			pad_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// output register: load a new result or drop a taken one
			if (st_q == T_RES && out_free) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			unique case (st_q)
				T_IDLE: begin
					if (acc) begin
						last_q <= s_tlast;
						if (in_rng) begin
							if (!past_hdr) begin
								method_q[cnt_q[1:0]*8 +: 8] <= s_tdata;
							end else begin
								buf_q[idx] <= s_tdata;
								if (!space_q && s_tdata == SPACE_CHAR) begin
									space_q <= 1'b1;
									uri_q   <= PATH_W'(cnt_q - CNT_W'(4));
									vok_q   <= 1'b1;
									vm_q    <= '0;
								end else if (space_q && vm_q < 4'(VERSION_LEN)) begin
									if (s_tdata != version_char(vm_q)) vok_q <= 1'b0;
									vm_q <= vm_q + 4'd1;
								end
								if (need_abs)
									bstart_q <= PATH_W'(cnt_q - CNT_W'(BLOCK_BYTES + 3));
							end
							tail_q <= {s_tdata, tail_q[31:8]};
						end
						if (cnt_q <= CNT_W'(MAX_REQUEST_BYTES)) cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				T_FIN: begin
					if (need_pad) begin
						pad_q    <= 1'b1;
						bstart_q <= PATH_W'(cnt_q - CNT_W'(4) - CNT_W'(fill));
						for (int i = 0; i < BLOCK_BYTES; i++)
							if (IDX_W'(i) >= fill) buf_q[i] <= 8'h00;
					end
				end
				T_RES: begin
					if (out_free) begin
						m_data_q  <= {1'b0,
							show ? uri_q : {PATH_W{1'b0}},
							show ? lanes01 : 64'd0,
							status};
						cnt_q    <= '0;
						method_q <= '0;
						space_q  <= 1'b0;
						uri_q    <= '0;
						bstart_q <= '0;
						vm_q     <= '0;
						vok_q    <= 1'b0;
						tail_q   <= '0;
						last_q   <= 1'b0;
						pad_q    <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire
